[rtl/cmsu_pkg.sv]
// Shared types and constants for the conservative-update count-min sketch.
// Used by cmsu_front, cmsu_queue, cmsu_back and the top level; no dependencies.
`default_nettype none

package cmsu_pkg;

  localparam int ROWS         = 4;
  localparam int ROW_BUCKETS  = 1024;
  localparam int COUNTER_BITS = 32;

  localparam int KEY_BITS    = 32;
  localparam int AMOUNT_BITS = 16;
  localparam int EST_BITS    = 32;
  localparam int SEED_BITS   = 32;

  localparam int SEED_COUNT    = 4;
  localparam int SEED_IDX_BITS = 2;
  localparam int CFG_IDX_BITS  = 8;

  // Hash keeps the top floor(log2(ROW_BUCKETS)) bits of the product.
  localparam int BUCKET_BITS = $clog2(ROW_BUCKETS + 1) - 1;
  localparam int ADDR_BITS   = $clog2(ROW_BUCKETS);

  // Level is the minimum plus the amount, one bit wider than the wider operand.
  localparam int LVL_BITS =
    ((COUNTER_BITS > AMOUNT_BITS) ? COUNTER_BITS : AMOUNT_BITS) + 1;

  localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  localparam logic [SEED_COUNT-1:0][SEED_BITS-1:0] SEED_RESET = {
    32'd668265263, 32'd3266489917, 32'd2246822519, 32'd2654435761
  };

  // One hashed request waiting for the counter update unit.
  typedef struct packed {
    logic                            action;
    logic [AMOUNT_BITS-1:0]          amount;
    logic [ROWS-1:0][ADDR_BITS-1:0]  addr;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MIN,
    ST_UPD
  } back_state_t;

endpackage

`default_nettype wire

[rtl/conservative_update_count_min_sketch.sv]
// A request passes the input register, the queue and the update unit's read, minimum and
// update states; the update state holds while the last result is not taken. The unit serves
// one request at a time, with conservative write-back for inserts; the queue takes more meanwhile.
// Reset: seeds return to their defaults, then a clearing pass zeroes all ROW_BUCKETS (1024)
// addresses in all rows in parallel; s_tready stays low until it ends.
// Depends on cmsu_pkg, cmsu_front, cmsu_queue and cmsu_back.
`default_nettype none

module conservative_update_count_min_sketch (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [cmsu_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire  [cmsu_pkg::SEED_BITS-1:0]     cfg_data,
  input  wire                                s_tvalid,
  output logic                               s_tready,
  input  wire  [47:0]                        s_tdata,  // key[31:0], amount[47:32]
  input  wire                                s_tuser,  // action
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [31:0]                        m_tdata,  // estimate[31:0]
  output logic                               m_tuser   // saturated
);

  logic                  push;
  logic                  pop;
  cmsu_pkg::item_t       push_item;
  cmsu_pkg::item_t       head;
  cmsu_pkg::queue_stat_t q_stat;
  cmsu_pkg::back_stat_t  b_stat;

  cmsu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_action  (s_tuser),
    .s_key     (s_tdata[31:0]),
    .s_amount  (s_tdata[47:32]),
    .push      (push),
    .push_item (push_item),
    .q_stat    (q_stat),
    .b_stat    (b_stat)
  );

  cmsu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  cmsu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .b_stat      (b_stat),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_estimate  (m_tdata),
    .m_saturated (m_tuser)
  );

endmodule

`default_nettype wire

[rtl/cmsu_front.sv]
// Front end: accepts requests, holds the seed registers and hashes each key
// into one bucket address per row. Depends on cmsu_pkg.
`default_nettype none

module cmsu_front (
  input  wire                                   clk,
  input  wire                                   rst,
  // Configuration write channel.
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  [cmsu_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire  [cmsu_pkg::SEED_BITS-1:0]        cfg_data,
  // Request stream.
  input  wire                                   s_tvalid,
  output logic                                  s_tready,
  input  wire                                   s_action,
  input  wire  [cmsu_pkg::KEY_BITS-1:0]         s_key,
  input  wire  [cmsu_pkg::AMOUNT_BITS-1:0]      s_amount,
  // To the queue.
  output logic                                  push,
  output cmsu_pkg::item_t                       push_item,
  input  cmsu_pkg::queue_stat_t                 q_stat,
  input  cmsu_pkg::back_stat_t                  b_stat
);

  logic [cmsu_pkg::SEED_COUNT-1:0][cmsu_pkg::SEED_BITS-1:0] seeds;

  logic                               iv;
  logic                               ia;
  logic [cmsu_pkg::KEY_BITS-1:0]      ik;
  logic [cmsu_pkg::AMOUNT_BITS-1:0]   iam;

  logic [cmsu_pkg::ROWS-1:0][31:0]    prod;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seeds <= cmsu_pkg::SEED_RESET;
    end else if (cfg_valid && cfg_index < cmsu_pkg::CFG_IDX_BITS'(cmsu_pkg::SEED_COUNT)) begin
      seeds[cfg_index[cmsu_pkg::SEED_IDX_BITS-1:0]] <= cfg_data;
    end
  end

  assign push     = iv && !q_stat.full;
  assign s_tready = !b_stat.clearing && (!iv || !q_stat.full);

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      iv <= 1'b1;
    end else if (push) begin
      iv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ia  <= s_action;
      ik  <= s_key;
      iam <= s_amount;
    end
  end

  // The product goes straight into a queue entry, so each multiplier is
  // followed by a register.
  always_comb begin
    push_item.action = ia;
    push_item.amount = iam;
    for (int r = 0; r < cmsu_pkg::ROWS; r++) begin
      prod[r] = ik * (seeds[r] | 32'd1);
      push_item.addr[r] =
        cmsu_pkg::ADDR_BITS'(prod[r][31 -: cmsu_pkg::BUCKET_BITS]);
    end
  end

endmodule

`default_nettype wire

[rtl/cmsu_queue.sv]
// Short request queue between the hash front end and the update unit.
// Depends on cmsu_pkg.
`default_nettype none

module cmsu_queue (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    push,
  input  cmsu_pkg::item_t        push_item,
  input  wire                    pop,
  output cmsu_pkg::item_t        head,
  output cmsu_pkg::queue_stat_t  q_stat
);

  cmsu_pkg::item_t                  entries [cmsu_pkg::QUEUE_DEPTH];
  logic [cmsu_pkg::QPTR_BITS-1:0]   wptr;
  logic [cmsu_pkg::QPTR_BITS-1:0]   rptr;
  logic [cmsu_pkg::QCNT_BITS-1:0]   count;

  assign q_stat.full  = (count == cmsu_pkg::QCNT_BITS'(cmsu_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign head         = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> !q_stat.full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cmsu_pkg::QCNT_BITS'(cmsu_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

[rtl/cmsu_back.sv]
// Update unit: owns the row counter memories, clears them after reset and
// runs read and minimum for each request, plus conservative write-back for inserts.
// Depends on cmsu_pkg.
`default_nettype none

module cmsu_back (
  input  wire                                 clk,
  input  wire                                 rst,
  input  cmsu_pkg::item_t                     head,
  input  cmsu_pkg::queue_stat_t               q_stat,
  output logic                                pop,
  output cmsu_pkg::back_stat_t                b_stat,
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  output logic [cmsu_pkg::EST_BITS-1:0]       m_estimate,
  output logic                                m_saturated
);

  cmsu_pkg::back_state_t state;
  cmsu_pkg::back_state_t state_next;

  cmsu_pkg::item_t                                     cur;
  logic [cmsu_pkg::ADDR_BITS-1:0]                      clr_cnt;
  logic [cmsu_pkg::ROWS-1:0][cmsu_pkg::COUNTER_BITS-1:0] rd;
  logic [cmsu_pkg::COUNTER_BITS-1:0]                   lowest;
  logic [cmsu_pkg::COUNTER_BITS-1:0]                   low_c;
  logic [cmsu_pkg::LVL_BITS-1:0]                       level_sum;
  logic                                                sat_c;
  logic [cmsu_pkg::COUNTER_BITS-1:0]                   level_c;
  logic [cmsu_pkg::ROWS-1:0]                           we;
  logic [cmsu_pkg::COUNTER_BITS-1:0]                   wdata;
  logic                                                load;

  assign b_stat.clearing = (state == cmsu_pkg::ST_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cmsu_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    low_c = rd[0];
    for (int r = 1; r < cmsu_pkg::ROWS; r++) begin
      if (rd[r] < low_c) begin
        low_c = rd[r];
      end
    end
  end

  always_comb begin
    level_sum = cmsu_pkg::LVL_BITS'(lowest) + cmsu_pkg::LVL_BITS'(cur.amount);
    sat_c     = (level_sum > cmsu_pkg::LVL_BITS'(cmsu_pkg::CNT_MAX));
    level_c   = sat_c ? cmsu_pkg::CNT_MAX : level_sum[cmsu_pkg::COUNTER_BITS-1:0];
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load       = 1'b0;
    we         = '0;
    wdata      = level_c;
    case (state)
      cmsu_pkg::ST_CLEAR: begin
        we    = '1;
        wdata = '0;
        if (clr_cnt == cmsu_pkg::ADDR_BITS'(cmsu_pkg::ROW_BUCKETS - 1)) begin
          state_next = cmsu_pkg::ST_IDLE;
        end
      end
      cmsu_pkg::ST_IDLE: begin
        if (!q_stat.empty) begin
          pop        = 1'b1;
          state_next = cmsu_pkg::ST_READ;
        end
      end
      cmsu_pkg::ST_READ: begin
        state_next = cmsu_pkg::ST_MIN;
      end
      cmsu_pkg::ST_MIN: begin
        state_next = cmsu_pkg::ST_UPD;
      end
      cmsu_pkg::ST_UPD: begin
        // The read data stays valid while the result register is occupied,
        // since the address and the memories do not change.
        if (!m_tvalid || m_tready) begin
          load       = 1'b1;
          state_next = cmsu_pkg::ST_IDLE;
          if (cur.action == cmsu_pkg::ACT_INSERT) begin
            for (int r = 0; r < cmsu_pkg::ROWS; r++) begin
              we[r] = (rd[r] < level_c);
            end
          end
        end
      end
      default: begin
        state_next = cmsu_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == cmsu_pkg::ST_CLEAR) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (state == cmsu_pkg::ST_MIN) begin
      lowest <= low_c;
    end
  end

  for (genvar g = 0; g < cmsu_pkg::ROWS; g++) begin : g_row
    logic [cmsu_pkg::COUNTER_BITS-1:0] mem [cmsu_pkg::ROW_BUCKETS];
    logic [cmsu_pkg::ADDR_BITS-1:0]    waddr;

    assign waddr = b_stat.clearing ? clr_cnt : cur.addr[g];

    always_ff @(posedge clk) begin
      if (we[g]) begin
        mem[waddr] <= wdata;
      end
      rd[g] <= mem[cur.addr[g]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (cur.action == cmsu_pkg::ACT_INSERT) begin
        m_estimate  <= cmsu_pkg::EST_BITS'(level_c);
        m_saturated <= sat_c;
      end else begin
        m_estimate  <= cmsu_pkg::EST_BITS'(lowest);
        m_saturated <= 1'b0;
      end
    end
  end

  a_sat_at_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_saturated |-> m_estimate == cmsu_pkg::EST_BITS'(cmsu_pkg::CNT_MAX))
    else $error("saturated result below counter maximum");

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == cmsu_pkg::ST_CLEAR |-> !pop && !m_tvalid)
    else $error("request taken during clearing pass");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    |we |-> state == cmsu_pkg::ST_CLEAR || state == cmsu_pkg::ST_UPD)
    else $error("counter write outside clear or update");

  a_load_result: assert property (@(posedge clk) disable iff (rst)
    load |=> m_tvalid && state == cmsu_pkg::ST_IDLE)
    else $error("result not presented after update");

endmodule

`default_nettype wire

[sim/count_estimate_checker.sv]
// Scoreboard for conservative_update_count_min_sketch: follows seed writes, predicts the
// estimate and saturation flag of each accepted request and compares results in order.
// Depends on cmsu_pkg.
`timescale 1ns / 100ps

module count_estimate_checker (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_valid,
  input  wire                                cfg_ready,
  input  wire  [cmsu_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire  [cmsu_pkg::SEED_BITS-1:0]     cfg_data,
  input  wire                                s_tvalid,
  input  wire                                s_tready,
  input  wire  [47:0]                        s_tdata,  // key[31:0], amount[47:32]
  input  wire                                s_tuser,  // action
  input  wire                                m_tvalid,
  input  wire                                m_tready,
  input  wire  [31:0]                        m_tdata,  // estimate[31:0]
  input  wire                                m_tuser,  // saturated
  output int                                 fail_count,
  output int                                 outstanding
);
  import cmsu_pkg::*;

  typedef struct packed {
    logic [EST_BITS-1:0] estimate;
    logic                saturated;
  } estimate_t;

  logic [SEED_BITS-1:0]    seed [SEED_COUNT];
  logic [COUNTER_BITS-1:0] tally [ROWS][ROW_BUCKETS];
  estimate_t               estimate_q [$];
  int                      result_count;

  initial begin
    fail_count   = 0;
    outstanding  = 0;
    result_count = 0;
  end

  task automatic report_mismatch(input string what);
    if (fail_count < 32) begin
      $display("mismatch at %0t ns, result %0d: %s", $time, result_count, what);
    end
    fail_count++;
  endtask

  function automatic logic [ADDR_BITS-1:0] bucket_of(input int row,
                                                     input logic [KEY_BITS-1:0] key);
    logic [31:0] product;
    product = key * (seed[row] | 32'd1);
    return product[31 -: BUCKET_BITS];
  endfunction

  // Applies one request to the shadow counters and returns what the block should answer.
  function automatic estimate_t apply_request(input logic action,
                                              input logic [KEY_BITS-1:0] key,
                                              input logic [AMOUNT_BITS-1:0] amount);
    logic [ADDR_BITS-1:0]    slot [ROWS];
    logic [COUNTER_BITS-1:0] lowest;
    logic [LVL_BITS-1:0]     level;
    estimate_t               answer;
    lowest = CNT_MAX;
    for (int r = 0; r < ROWS; r++) begin
      slot[r] = bucket_of(r, key);
      if (tally[r][slot[r]] < lowest) lowest = tally[r][slot[r]];
    end
    answer.saturated = 1'b0;
    if (action == ACT_INSERT) begin
      level = LVL_BITS'(lowest) + LVL_BITS'(amount);
      if (level > LVL_BITS'(CNT_MAX)) begin
        level            = LVL_BITS'(CNT_MAX);
        answer.saturated = 1'b1;
      end
      // Only counters below the new level move; the others already cover it.
      for (int r = 0; r < ROWS; r++) begin
        if (LVL_BITS'(tally[r][slot[r]]) < level) tally[r][slot[r]] = level[COUNTER_BITS-1:0];
      end
      answer.estimate = level[EST_BITS-1:0];
    end else begin
      answer.estimate = lowest;
    end
    return answer;
  endfunction

  always @(posedge clk) begin
    estimate_t want;
    if (rst) begin
      for (int i = 0; i < SEED_COUNT; i++) seed[i] = SEED_RESET[i];
      for (int r = 0; r < ROWS; r++) begin
        for (int b = 0; b < ROW_BUCKETS; b++) tally[r][b] = '0;
      end
      estimate_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (estimate_q.size() == 0) begin
          report_mismatch($sformatf("result %h sat %b with no request waiting",
                                    m_tdata, m_tuser));
        end else begin
          want = estimate_q.pop_front();
          if (m_tdata !== want.estimate) begin
            report_mismatch($sformatf("estimate %h, expected %h", m_tdata, want.estimate));
          end
          if (m_tuser !== want.saturated) begin
            report_mismatch($sformatf("saturated %b, expected %b", m_tuser, want.saturated));
          end
        end
        result_count++;
      end
      if (cfg_valid && cfg_ready && cfg_index < SEED_COUNT) begin
        seed[cfg_index[SEED_IDX_BITS-1:0]] = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        estimate_q.insert(estimate_q.size(),
                          apply_request(s_tuser, s_tdata[31:0], s_tdata[47:32]));
      end
    end
    outstanding <= estimate_q.size();
  end

endmodule

[sim/conservative_update_count_min_sketch_test.sv]
// Top of the sketch testbench: clock, reset, seed programming and request stimulus.
// Depends on cmsu_pkg, the block and count_estimate_checker, which checks the results.
`timescale 1ns / 100ps

module conservative_update_count_min_sketch_test;
  import cmsu_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] REG_SEED_ROW_ZERO  = 0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SEED_ROW_ONE   = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SEED_ROW_TWO   = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SEED_ROW_THREE = 3;

  localparam int STALL_CYCLES     = 300;

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [SEED_BITS-1:0]    cfg_data  = '0;
  logic                    s_tvalid  = 1'b0;
  logic [47:0]             s_tdata   = '0;
  logic                    s_tuser   = 1'b0;
  logic                    m_tready  = 1'b0;
  wire                     cfg_ready;
  wire                     s_tready;
  wire                     m_tvalid;
  wire  [31:0]             m_tdata;
  wire                     m_tuser;
  int                      fail_count;
  int                      outstanding;

  int            send_idle_pct = 26;
  int            recv_idle_pct = 52;
  logic          stall_toggle  = 1'b0;
  logic          stall_seen    = 1'b0;
  int            stall_left    = 0;
  logic [31:0]   key_pool [32];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  conservative_update_count_min_sketch dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  count_estimate_checker estimate_check (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  // Result side: random back-pressure, plus a long hold-off whenever the toggle flips.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_toggle != stall_seen) begin
      stall_seen <= stall_toggle;
      stall_left <= STALL_CYCLES;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_request(input logic action, input logic [31:0] key,
                              input logic [15:0] amount);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= action;
    s_tdata  <= {amount, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_random_request();
    logic [31:0] key;
    logic [15:0] amount;
    logic        action;
    int          pick;
    pick   = $urandom_range(99);
    key    = (pick < 70) ? key_pool[$urandom_range(31)] : $urandom();
    action = ($urandom_range(99) < 40) ? ACT_QUERY : ACT_INSERT;
    pick   = $urandom_range(99);
    if (pick < 45) amount = 16'($urandom_range(15));
    else if (pick < 80) amount = 16'($urandom());
    else if (pick < 90) amount = '0;
    else amount = '1;
    send_request(action, key, amount);
  endtask

  // Holds the request side idle until every accepted request has its result.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_BITS-1:0] index,
                                input logic [SEED_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Every seed set also carries one write to an unmapped index, which must change nothing.
  task automatic program_seeds(input logic [31:0] s0, input logic [31:0] s1,
                               input logic [31:0] s2, input logic [31:0] s3);
    write_register(REG_SEED_ROW_ZERO, s0);
    write_register(CFG_IDX_BITS'($urandom_range(255, SEED_COUNT)), $urandom());
    write_register(REG_SEED_ROW_ONE, s1);
    write_register(REG_SEED_ROW_TWO, s2);
    write_register(REG_SEED_ROW_THREE, s3);
  endtask

  initial begin
    // Half the pool shares a few top-bit patterns, so those keys collide in any row
    // whose seed is one or zero.
    for (int i = 0; i < 32; i++) begin
      key_pool[i] = (i < 16) ? {10'($urandom_range(3)), 22'($urandom())} : $urandom();
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part with the seeds at their reset values.
    send_request(ACT_QUERY,  32'h0000_0000, 16'h0000);
    send_request(ACT_INSERT, 32'h0000_0000, 16'h0000);
    send_request(ACT_INSERT, 32'h0000_0000, 16'hFFFF);
    send_request(ACT_QUERY,  32'h0000_0000, 16'hFFFF);
    send_request(ACT_INSERT, 32'hFFFF_FFFF, 16'h0001);
    send_request(ACT_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(ACT_QUERY,  32'hFFFF_FFFF, 16'h0000);
    send_request(ACT_INSERT, 32'h0000_0000, 16'h0000);
    send_request(ACT_INSERT, 32'h8000_0000, 16'h0007);
    send_request(ACT_INSERT, 32'h0000_0001, 16'h0003);
    send_request(ACT_INSERT, 32'hA5A5_5A5A, 16'h8000);
    send_request(ACT_QUERY,  32'hA5A5_5A5A, 16'h1234);
    send_request(ACT_INSERT, 32'hA5A5_5A5A, 16'h7FFF);
    send_request(ACT_QUERY,  32'h5A5A_A5A5, 16'h0000);
    for (int i = 0; i < 5; i++) begin
      send_request(ACT_INSERT, key_pool[i], 16'($urandom()));
      send_request(ACT_QUERY, key_pool[i], 16'($urandom()));
    end
    wait_drained();

    program_seeds(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    for (int i = 0; i < 200; i++) begin
      if (i == 80) stall_toggle <= ~stall_toggle;
      send_random_request();
    end
    wait_drained();

    send_idle_pct = 52;
    recv_idle_pct <= 26;
    program_seeds($urandom(), $urandom(), $urandom(), $urandom());
    for (int i = 0; i < 200; i++) begin
      if (i == 100) wait_drained();
      send_random_request();
    end
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    program_seeds(SEED_RESET[0], 32'hFFFF_FFFE, $urandom(), SEED_RESET[3]);
    for (int i = 0; i < 150; i++) send_random_request();
    wait_drained();

    repeat (20) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

[files.f]
rtl/cmsu_pkg.sv
rtl/cmsu_front.sv
rtl/cmsu_queue.sv
rtl/cmsu_back.sv
rtl/conservative_update_count_min_sketch.sv
sim/count_estimate_checker.sv
sim/conservative_update_count_min_sketch_test.sv
